>>> rtl/core/et_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// et_pkg
// Types and constants shared by the four-channel encoder tachometer.
// ----------------------------------------------------------------------------
package et_pkg;

  localparam int CHANNELS    = 4;
  localparam int COUNT_W     = 16;
  localparam int SPEED_W     = 17;
  localparam int LIMIT_W     = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd25;

  localparam logic ACTION_PINS = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  // speed = count * 300 / 220 = count * 15 / 11
  // 15 * ceil(2^24 / 11), exact for every 16-bit count
  localparam int                SPEED_SHIFT = 24;
  localparam int                SPEED_K_W   = 25;
  localparam logic [SPEED_K_W-1:0] SPEED_K  = 25'd22878030;
  localparam int                PROD_W      = COUNT_W + SPEED_K_W;

  typedef struct packed {
    logic       action;
    logic [3:0] encoder_lines;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_ch0;
    logic [SPEED_W-1:0] speed_ch1;
    logic [SPEED_W-1:0] speed_ch2;
    logic [SPEED_W-1:0] speed_ch3;
  } out_item_t;

  typedef struct packed {
    logic inc;
    logic close;
    logic latch;
  } lane_ctl_t;

endpackage

>>> rtl/core/et_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// et_window
// Window tick counter and limit register; flags the tick that closes a window.
// ----------------------------------------------------------------------------
module et_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [et_pkg::LIMIT_W-1:0] cfg_wdata,
  input  logic                      tick,
  output logic                      close
);
  import et_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic [LIMIT_W-1:0] ticks_r;
  logic [LIMIT_W-1:0] ticks_nxt;

  assign close = tick && (ticks_r >= limit_r);

  always_comb begin
    ticks_nxt = ticks_r;
    if (tick) begin
      if (close) begin
        ticks_nxt = '0;
      end else begin
        ticks_nxt = ticks_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      ticks_r <= '0;
    end else begin
      ticks_r <= ticks_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

endmodule

>>> rtl/core/et_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// et_lane
// One channel: pulse counter, speed multiply stage and latched speed.
// ----------------------------------------------------------------------------
module et_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  et_pkg::lane_ctl_t         ctl,
  output logic [et_pkg::SPEED_W-1:0] speed
);
  import et_pkg::*;

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [PROD_W-1:0]  prod;
  logic [SPEED_W-1:0] calc_r;
  logic [SPEED_W-1:0] speed_r;

  assign prod  = PROD_W'(count_r) * PROD_W'(SPEED_K);
  assign speed = speed_r;

  always_comb begin
    count_nxt = count_r;
    if (ctl.close) begin
      count_nxt = '0;
    end else if (ctl.inc) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      speed_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (ctl.latch) begin
        speed_r <= calc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.close) begin
      calc_r <= prod[SPEED_SHIFT +: SPEED_W];
    end
  end

endmodule

>>> rtl/core/encoder_tachometer_four_channel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_tachometer_four_channel
// Four-channel encoder tachometer with windowed speed measurement.
//
// Input requests carry either a sample of the four encoder lines (action 0)
// or a timer tick (action 1). Every request gives exactly one result request
// holding the four latched speeds in revolutions per minute, taking effect of
// that request. A tick that closes the window latches count * 300 / 220 for
// each channel and clears the counts.
// Throughput is one request per cycle unless out_stall holds a result.
// From acceptance to out_valid a request passes the per-lane speed multiplier
// register and then the latched speed/output register.
// The user must write the window limit through cfg_we / cfg_wdata only while
// idle; the block does not enforce this. Reset clears counts, speeds and the
// tick counter and sets the limit to 25. When out_stall holds a pending
// result the whole pipeline holds and in_stall is raised in the same cycle.
// ----------------------------------------------------------------------------
module encoder_tachometer_four_channel (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  et_pkg::in_item_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output et_pkg::out_item_t         out_data,
  input  logic                      cfg_we,
  input  logic [et_pkg::LIMIT_W-1:0] cfg_wdata
);
  import et_pkg::*;

  logic                ce;
  logic                in_acc;
  logic                tick;
  logic                close;
  logic [3:0]          prev_r;
  logic [3:0]          changed;
  logic                s1_valid_r;
  logic                s1_close_r;
  logic                out_valid_r;
  lane_ctl_t           ctl [CHANNELS];
  logic [SPEED_W-1:0]  speed [CHANNELS];

  assign ce       = !out_valid_r || !out_stall;
  assign in_stall = !ce;
  assign in_acc   = in_valid && ce;
  assign tick     = in_acc && (in_data.action == ACTION_TICK);
  assign changed  = prev_r ^ in_data.encoder_lines;

  et_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tick      (tick),
    .close     (close)
  );

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    always_comb begin
      ctl[g].inc   = in_acc && (in_data.action == ACTION_PINS) && changed[g];
      ctl[g].close = close;
      ctl[g].latch = ce && s1_valid_r && s1_close_r;
    end

    et_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl[g]),
      .speed (speed[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      s1_valid_r  <= 1'b0;
      s1_close_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc && (in_data.action == ACTION_PINS)) begin
        prev_r <= in_data.encoder_lines;
      end
      if (ce) begin
        s1_valid_r  <= in_acc;
        s1_close_r  <= close;
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // merge lanes into the result
  assign out_valid          = out_valid_r;
  assign out_data.speed_ch0 = speed[0];
  assign out_data.speed_ch1 = speed[1];
  assign out_data.speed_ch2 = speed[2];
  assign out_data.speed_ch3 = speed[3];

endmodule
